@@ sv/smsm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smsm_pkg
// Shared types, codes and helpers for the motor speed model.
// ----------------------------------------------------------------------------
package smsm_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_MUL1, ST_STEP1, ST_FSET, ST_MUL2,
    ST_FRIC, ST_DSET, ST_DIV, ST_WB, ST_READ
  } state_t;

  localparam logic [1:0] K_TICK = 2'd0;
  localparam logic [1:0] K_CMD  = 2'd1;
  localparam logic [1:0] K_READ = 2'd2;

  localparam logic [2:0] M_DUTY    = 3'd0;
  localparam logic [2:0] M_CURRENT = 3'd1;
  localparam logic [2:0] M_BRAKE   = 3'd2;
  localparam logic [2:0] M_SPEED   = 3'd3;

  localparam logic [2:0] R_RUNNING  = 3'd0;
  localparam logic [2:0] R_TIMEOUT  = 3'd1;
  localparam logic [2:0] R_SPD_MAX  = 3'd2;
  localparam logic [2:0] R_SPD_STEP = 3'd3;
  localparam logic [2:0] R_CUR_GAIN = 3'd4;
  localparam logic [2:0] R_FRIC_FAC = 3'd5;
  localparam logic [2:0] R_FRIC_STP = 3'd6;
  localparam logic [2:0] R_BRK_VAL  = 3'd7;

  localparam logic [9:0]  DIV_K     = 10'd1000;
  localparam logic [40:0] ROUND_ADD = 41'd500;
  localparam logic [5:0]  MUL_LAST  = 6'd32;
  localparam logic [5:0]  DIV_LAST  = 6'd40;
  localparam logic [15:0] IDLE_MAX  = 16'hFFFF;

  function automatic logic [39:0] mag40(input logic [39:0] x);
    return x[39] ? (~x + 40'd1) : x;
  endfunction

  // move c toward g by at most st, never past g
  function automatic logic [39:0] step_to(input logic [39:0] c, input logic [39:0] g,
                                          input logic [39:0] st);
    logic [40:0] d;
    logic [40:0] dm;
    d  = {g[39], g} - {c[39], c};
    dm = d[40] ? (~d + 41'd1) : d;
    if (dm <= {1'b0, st}) return g;
    return d[40] ? (c - st) : (c + st);
  endfunction

endpackage
`default_nettype wire

@@ sv/simple_motor_speed_model_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// simple_motor_speed_model_top
// Speed, tachometer and timeout model for a set of motors.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready: a tick, a set command or a read.
// Commands are applied in the idle state. A read's result is registered and held
// on out_valid/out_ready until taken; a further read waits while a result is
// pending, ticks and commands are still taken.
// A tick walks the motors one after another. Per motor: a load state, the
// shift-add multiplier for the goal or step (duty, current, brake modes), a
// step state (those modes and speed mode), a setup and the multiplier again
// for friction (all but speed mode), a friction state, a setup and the
// restoring divide by 1000 for the tachometer, and a write-back. A tick
// holds the input from its acceptance until the last motor is written back.
// Reset clears all motor state at once and loads the register defaults;
// the block is stopped until running is written to one.
// ----------------------------------------------------------------------------
module simple_motor_speed_model_top
  import smsm_pkg::*;
#(
  parameter int MOTORS = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [32:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic               motor,
  input  wire logic [2:0]         mode,
  input  wire logic signed [39:0] value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    motor_out,
  output logic signed [39:0]      speed,
  output logic signed [47:0]      tacho,
  output logic [47:0]             tacho_abs
);

  localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  logic        running;
  logic [15:0] timeout_ticks;
  logic [32:0] speed_max;
  logic [31:0] speed_step;
  logic [31:0] current_step_gain;
  logic [16:0] friction_factor;
  logic [31:0] friction_step;
  logic [32:0] timeout_brake_value;

  logic [39:0] m_spd [MOTORS];
  logic [2:0]  m_mode [MOTORS];
  logic [39:0] m_val [MOTORS];
  logic [15:0] m_idle [MOTORS];
  logic [47:0] m_ts [MOTORS];
  logic [47:0] m_tu [MOTORS];

  state_t state, state_next;
  logic [IW-1:0] cur;
  logic [5:0]  cnt;
  logic [39:0] s_r, v_r;
  logic [2:0]  m_r;
  logic [39:0] ma;
  logic [32:0] mb;
  logic [39:0] hi;
  logic [32:0] lo;
  logic [40:0] q;
  logic [9:0]  rem;

  logic        in_acc, motor_ok, last;
  logic [40:0] msum;
  logic [39:0] mres;
  logic [10:0] dt;
  logic [39:0] goal, stp;
  logic [15:0] idle_inc;
  logic [47:0] inc;

  assign in_acc   = in_valid && in_ready;
  assign motor_ok = (32'(motor) < MOTORS);
  assign last     = (cur == IW'(MOTORS - 1));
  assign msum     = {1'b0, hi} + (mb[0] ? {1'b0, ma} : 41'd0);
  assign mres     = (|hi[39:22]) ? {1'b0, {39{1'b1}}} : {1'b0, hi[21:0], lo[32:16]};
  assign dt       = {rem, q[40]};
  assign inc      = {7'd0, q};
  assign idle_inc = (m_idle[cur] < IDLE_MAX) ? (m_idle[cur] + 16'd1) : m_idle[cur];

  always_comb begin
    goal = v_r;
    stp  = {8'd0, speed_step};
    case (m_r)
      M_DUTY: begin
        goal = v_r[39] ? (~mres + 40'd1) : mres;
      end
      M_CURRENT: begin
        goal = v_r[39] ? (~{7'd0, speed_max} + 40'd1) : {7'd0, speed_max};
        stp  = mres;
      end
      M_BRAKE: begin
        goal = 40'd0;
        stp  = mres;
      end
      default: begin
        goal = v_r;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && running && kind == K_TICK) state_next = ST_LOAD;
        else if (in_acc && running && kind == K_READ && motor_ok) state_next = ST_READ;
      end
      ST_LOAD: begin
        if (m_mode[cur] == M_SPEED) state_next = ST_STEP1;
        else if (m_mode[cur] <= M_BRAKE) state_next = ST_MUL1;
        else state_next = ST_FSET;
      end
      ST_MUL1:  if (cnt == MUL_LAST) state_next = ST_STEP1;
      ST_STEP1: state_next = (m_r == M_SPEED) ? ST_DSET : ST_FSET;
      ST_FSET:  state_next = ST_MUL2;
      ST_MUL2:  if (cnt == MUL_LAST) state_next = ST_FRIC;
      ST_FRIC:  state_next = ST_DSET;
      ST_DSET:  state_next = ST_DIV;
      ST_DIV:   if (cnt == DIV_LAST) state_next = ST_WB;
      ST_WB:    state_next = last ? ST_IDLE : ST_LOAD;
      ST_READ:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE) && (kind != K_READ || !out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cur   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_acc && kind == K_TICK) cur <= '0;
          else if (in_acc) cur <= IW'(motor);
        end
        ST_MUL1, ST_MUL2, ST_DIV: cnt <= cnt + 6'd1;
        ST_WB: begin
          cnt <= '0;
          if (!last) cur <= cur + IW'(1);
        end
        default: cnt <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        s_r <= m_spd[cur];
        v_r <= m_val[cur];
        m_r <= m_mode[cur];
        ma  <= mag40(m_val[cur]);
        mb  <= (m_mode[cur] == M_DUTY) ? speed_max : {1'b0, current_step_gain};
        hi  <= '0;
        lo  <= '0;
      end
      ST_MUL1, ST_MUL2: begin
        hi <= msum[40:1];
        lo <= {msum[0], lo[32:1]};
        mb <= {1'b0, mb[32:1]};
      end
      ST_STEP1: s_r <= step_to(s_r, goal, stp);
      ST_FSET: begin
        ma <= mag40(s_r);
        mb <= {16'd0, friction_factor};
        hi <= '0;
        lo <= '0;
      end
      ST_FRIC: s_r <= step_to(s_r[39] ? (~mres + 40'd1) : mres, 40'd0, {8'd0, friction_step});
      ST_DSET: begin
        q   <= {1'b0, mag40(s_r)} + ROUND_ADD;
        rem <= '0;
      end
      ST_DIV: begin
        if (dt >= {1'b0, DIV_K}) begin
          rem <= 10'(dt - {1'b0, DIV_K});
          q   <= {q[39:0], 1'b1};
        end else begin
          rem <= dt[9:0];
          q   <= {q[39:0], 1'b0};
        end
      end
      default: begin
        s_r <= s_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        m_spd[i]  <= '0;
        m_mode[i] <= M_DUTY;
        m_val[i]  <= '0;
        m_idle[i] <= '0;
        m_ts[i]   <= '0;
        m_tu[i]   <= '0;
      end
    end else if (state == ST_IDLE) begin
      if (in_acc && running && kind == K_CMD && motor_ok) begin
        m_mode[IW'(motor)] <= mode;
        m_val[IW'(motor)]  <= value;
        m_idle[IW'(motor)] <= '0;
      end
    end else if (state == ST_WB) begin
      m_spd[cur]  <= s_r;
      m_ts[cur]   <= s_r[39] ? (m_ts[cur] - inc) : (m_ts[cur] + inc);
      m_tu[cur]   <= m_tu[cur] + inc;
      m_idle[cur] <= idle_inc;
      if (idle_inc > timeout_ticks) begin
        m_mode[cur] <= M_BRAKE;
        m_val[cur]  <= {7'd0, timeout_brake_value};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_READ) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      motor_out <= cur[0];
      speed     <= m_spd[cur];
      tacho     <= m_ts[cur];
      tacho_abs <= m_tu[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running             <= 1'b0;
      timeout_ticks       <= 16'd200;
      speed_max           <= 33'd2658140160;
      speed_step          <= 32'd16384000;
      current_step_gain   <= 32'd204800;
      friction_factor     <= 17'd65467;
      friction_step       <= 32'd327680;
      timeout_brake_value <= 33'd655360;
    end else if (cfg_write) begin
      case (cfg_index)
        R_RUNNING:  running             <= cfg_data[0];
        R_TIMEOUT:  timeout_ticks       <= cfg_data[15:0];
        R_SPD_MAX:  speed_max           <= cfg_data;
        R_SPD_STEP: speed_step          <= cfg_data[31:0];
        R_CUR_GAIN: current_step_gain   <= cfg_data[31:0];
        R_FRIC_FAC: friction_factor     <= cfg_data[16:0];
        R_FRIC_STP: friction_step       <= cfg_data[31:0];
        R_BRK_VAL:  timeout_brake_value <= cfg_data;
        default:    running             <= running;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ bench/simple_motor_speed_model_top_tb.sv @@
// ----------------------------------------------------------------------------
// simple_motor_speed_model_top_tb
// Self-checking bench for the motor speed model.
// ----------------------------------------------------------------------------
// Sends ticks, set commands and reads, including kind codes the block should
// ignore. An internal model tracks each motor's speed, tachometer counts and
// idle timeout, and every read result is compared with it field by field.
// Register settings change only while the block is idle.
// ----------------------------------------------------------------------------
module simple_motor_speed_model_top_tb;
  import smsm_pkg::*;

  localparam int NMOT = 2;
  localparam logic [1:0] K_BAD = 2'd3;
  localparam logic [39:0] SPD_LIM = 40'h7F_FFFF_FFFF;

  typedef struct packed {
    logic        m;
    logic [39:0] spd;
    logic [47:0] tac;
    logic [47:0] tabs;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [32:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic motor = 1'b0;
  logic [2:0] mode = '0;
  logic signed [39:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic motor_out;
  logic signed [39:0] speed;
  logic signed [47:0] tacho;
  logic [47:0] tacho_abs;

  simple_motor_speed_model_top #(.MOTORS(NMOT)) u_dut (.*);

  always #10 clk = ~clk;

  // shadow registers and motor state
  logic        run_en;
  logic [15:0] tmo_ticks;
  logic [32:0] spd_max, brk_val;
  logic [31:0] spd_step, cur_gain, fric_step;
  logic [16:0] fric_fac;
  logic [39:0] m_speed [NMOT];
  logic [2:0]  m_mode  [NMOT];
  logic [39:0] m_value [NMOT];
  logic [15:0] m_idle  [NMOT];
  logic [47:0] m_tac   [NMOT];
  logic [47:0] m_tabs  [NMOT];

  report_t pending_reads[$];
  int errors = 0;
  int n_reports = 0;
  int n_sent = 0;
  bit quiet_in = 1'b0, quiet_out = 1'b0;

  function automatic logic [39:0] absval(logic [39:0] x);
    return x[39] ? -x : x;
  endfunction

  function automatic logic [39:0] mulq(logic [39:0] mg, logic [32:0] k);
    logic [79:0] p;
    p = ({40'd0, mg} * {47'd0, k}) >> 16;
    return (p > {40'd0, SPD_LIM}) ? SPD_LIM : p[39:0];
  endfunction

  function automatic logic [39:0] move_to(logic [39:0] c, logic [39:0] g, logic [39:0] st);
    logic signed [40:0] d;
    logic [40:0] dm;
    d = $signed({g[39], g}) - $signed({c[39], c});
    dm = d[40] ? -d : d;
    if (dm <= {1'b0, st}) return g;
    return d[40] ? c - st : c + st;
  endfunction

  task automatic advance_motor(int i);
    logic [39:0] s, v, g, f;
    logic [47:0] inc;
    logic [2:0] md;
    s = m_speed[i];
    v = m_value[i];
    md = m_mode[i];
    case (md)
      M_DUTY: begin
        g = mulq(absval(v), spd_max);
        s = move_to(s, v[39] ? -g : g, {8'd0, spd_step});
      end
      M_CURRENT: begin
        g = {7'd0, spd_max};
        s = move_to(s, v[39] ? -g : g, mulq(absval(v), {1'b0, cur_gain}));
      end
      M_BRAKE: s = move_to(s, '0, mulq(absval(v), {1'b0, cur_gain}));
      M_SPEED: s = move_to(s, v, {8'd0, spd_step});
      default: ;
    endcase
    if (md != M_SPEED) begin
      f = mulq(absval(s), {16'd0, fric_fac});
      s = s[39] ? -f : f;
      s = move_to(s, '0, {8'd0, fric_step});
    end
    m_speed[i] = s;
    inc = ({8'd0, absval(s)} + 48'd500) / 48'd1000;
    m_tac[i] = s[39] ? m_tac[i] - inc : m_tac[i] + inc;
    m_tabs[i] = m_tabs[i] + inc;
    if (m_idle[i] != IDLE_MAX) m_idle[i]++;
    if (m_idle[i] > tmo_ticks) begin
      m_mode[i] = M_BRAKE;
      m_value[i] = {7'd0, brk_val};
    end
  endtask

  task automatic predict_request(logic [1:0] k, logic mi, logic [2:0] md, logic [39:0] v);
    if (!run_en) return;
    case (k)
      K_TICK: for (int i = 0; i < NMOT; i++) advance_motor(i);
      K_CMD: begin
        m_mode[mi] = md;
        m_value[mi] = v;
        m_idle[mi] = '0;
      end
      K_READ: pending_reads.push_back({mi, m_speed[mi], m_tac[mi], m_tabs[mi]});
      default: ;
    endcase
  endtask

  task automatic model_reset();
    run_en = 1'b0; tmo_ticks = 16'd200; spd_max = 33'd2658140160; spd_step = 32'd16384000;
    cur_gain = 32'd204800; fric_fac = 17'd65467; fric_step = 32'd327680;
    brk_val = 33'd655360;
    for (int i = 0; i < NMOT; i++) begin
      m_speed[i] = '0; m_mode[i] = M_DUTY; m_value[i] = '0;
      m_idle[i] = '0; m_tac[i] = '0; m_tabs[i] = '0;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    // a tick can still be walking the motors
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [32:0] d);
    in_valid <= 1'b0;
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      R_RUNNING:  run_en = d[0];
      R_TIMEOUT:  tmo_ticks = d[15:0];
      R_SPD_MAX:  spd_max = d;
      R_SPD_STEP: spd_step = d[31:0];
      R_CUR_GAIN: cur_gain = d[31:0];
      R_FRIC_FAC: fric_fac = d[16:0];
      R_FRIC_STP: fric_step = d[31:0];
      default:    brk_val = d;
    endcase
    @(posedge clk);
  endtask

  task automatic send_request(logic [1:0] k, logic mi, logic [2:0] md, logic [39:0] v);
    while (!quiet_in && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; kind <= k; motor <= mi; mode <= md; value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(k, mi, md, v);
    n_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst) out_ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    report_t exp_r;
    if (!rst && out_valid && out_ready) begin
      n_reports++;
      if (pending_reads.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected read result motor=%0d", motor_out);
      end else begin
        exp_r = pending_reads.pop_front();
        if (exp_r.m !== motor_out || exp_r.spd !== speed || exp_r.tac !== tacho ||
            exp_r.tabs !== tacho_abs) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp m=%0d spd=%h tac=%h abs=%h got m=%0d spd=%h tac=%h abs=%h",
                     exp_r.m, exp_r.spd, exp_r.tac, exp_r.tabs,
                     motor_out, speed, tacho, tacho_abs);
        end
      end
    end
  end

  function automatic logic [39:0] rand_value();
    case ($urandom_range(5))
      0: return 40'({$urandom, $urandom});
      1: return 40'h80_0000_0000 >>> $urandom_range(39);
      2: return {24'd0, 16'($urandom)} << $urandom_range(8);
      3: return -({24'd0, 16'($urandom)} << $urandom_range(8));
      default: return 40'($signed(17'($urandom_range(131072)) - 17'sd65536));
    endcase
  endfunction

  task automatic test_directed();
    write_reg(R_RUNNING, 33'd1);
    send_request(K_READ, 1'b0, M_DUTY, '0);
    send_request(K_CMD, 1'b0, M_DUTY, 40'sd65536);
    send_request(K_CMD, 1'b1, M_SPEED, 40'h7F_FFFF_FFFF);
    send_request(K_TICK, 1'b0, M_DUTY, '0);
    send_request(K_READ, 1'b0, M_DUTY, '0);
    send_request(K_READ, 1'b1, M_DUTY, '0);
    send_request(K_CMD, 1'b0, M_CURRENT, 40'h80_0000_0000);
    send_request(K_CMD, 1'b1, M_BRAKE, 40'sd655360);
    send_request(K_TICK, 1'b0, M_DUTY, '0);
    send_request(K_CMD, 1'b0, 3'd4, 40'sd1);
    send_request(K_CMD, 1'b1, 3'd7, -40'sd1);
    send_request(K_TICK, 1'b0, M_DUTY, '0);
    send_request(K_BAD, 1'b1, 3'd7, 40'h7F_FFFF_FFFF);
    send_request(K_READ, 1'b0, M_DUTY, '0);
    send_request(K_READ, 1'b1, M_DUTY, '0);
    send_request(K_CMD, 1'b0, M_SPEED, -40'sd1000000);
    send_request(K_CMD, 1'b1, 3'd5, '0);
    send_request(K_TICK, 1'b0, M_DUTY, '0);
    send_request(K_READ, 1'b0, M_DUTY, '0);
    wait_drained();
    write_reg(R_RUNNING, 33'd0);
    send_request(K_TICK, 1'b0, M_DUTY, '0);
    send_request(K_READ, 1'b1, M_DUTY, '0);
    send_request(K_CMD, 1'b1, M_DUTY, 40'sd5);
    write_reg(R_RUNNING, 33'd1);
  endtask

  task automatic random_burst(int n, int tick_pct);
    logic [1:0] k;
    int r;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < tick_pct) k = K_TICK;
      else if (r < tick_pct + 25) k = K_CMD;
      else if (r < 97) k = K_READ;
      else k = K_BAD;
      send_request(k, 1'($urandom), 3'($urandom), rand_value());
    end
  endtask

  task automatic test_settings();
    // defaults, then extremes, then random settings
    random_burst(250, 45);
    wait_drained();
    write_reg(R_TIMEOUT, 33'd0); write_reg(R_SPD_MAX, '1); write_reg(R_SPD_STEP, '1);
    write_reg(R_CUR_GAIN, '1); write_reg(R_FRIC_FAC, 33'd65536);
    write_reg(R_FRIC_STP, 33'd0); write_reg(R_BRK_VAL, '1);
    random_burst(200, 45);
    wait_drained();
    write_reg(R_TIMEOUT, 33'hFFFF); write_reg(R_SPD_MAX, 33'd0); write_reg(R_SPD_STEP, 33'd0);
    write_reg(R_CUR_GAIN, 33'd0); write_reg(R_FRIC_FAC, 33'd0);
    write_reg(R_FRIC_STP, 33'hFFFF_FFFF); write_reg(R_BRK_VAL, 33'd0);
    random_burst(150, 40);
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_reg(R_TIMEOUT, 33'($urandom_range(30)));
      write_reg(R_SPD_MAX, {1'($urandom), 32'($urandom)});
      write_reg(R_SPD_STEP, 33'($urandom >> $urandom_range(31)));
      write_reg(R_CUR_GAIN, 33'($urandom >> $urandom_range(31)));
      write_reg(R_FRIC_FAC, 33'($urandom_range(65536, 60000)));
      write_reg(R_FRIC_STP, 33'($urandom >> $urandom_range(31)));
      write_reg(R_BRK_VAL, {1'($urandom), 32'($urandom)} >> $urandom_range(32));
      if (p == 2) begin
        quiet_in = 1'b1; quiet_out = 1'b1;
      end
      random_burst(250, 50);
      quiet_in = 1'b0; quiet_out = 1'b0;
    end
  endtask

  task automatic test_pause();
    random_burst(60, 40);
    wait_drained();
    random_burst(40, 40);
  endtask

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings();
    test_pause();
    wait_drained();
    $display("sent %0d requests, checked %0d read results over several register settings",
             n_sent, n_reports);
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("mismatches: %0d, reads outstanding: %0d", errors, pending_reads.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
